FILE: sv/kmds_pkg.sv
// Package for the 4x4 keypad scanner: sizes, mode codes, controller states
// and the command and status structs between controller and datapath.
// Depends on nothing.
package kmds_pkg;

    localparam int HISTORY_BITS = 8;
    localparam int NUM_ROWS     = 4;
    localparam int NUM_COLS     = 4;
    localparam int ROW_W        = 2;
    localparam int COL_W        = 2;
    localparam int KEY_W        = 4;

    // Item mode codes.
    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_POLL = 4'b0100,
        ST_DONE = 4'b1000
    } kmds_state_t;

    typedef struct packed {
        logic load;       // capture an accepted beat, restart the poll sweep
        logic scan;       // shift the row sample into the current column
        logic poll_step;  // compare one column of keys
        logic out_load;   // move the result into the output register
    } kmds_cmd_t;

    typedef struct packed {
        logic poll_last;  // the poll sweep is on its final column
    } kmds_status_t;

    // Active-low one-hot drive for a column.
    function automatic logic [NUM_COLS-1:0] drive_for(input logic [COL_W-1:0] col);
        logic [NUM_COLS-1:0] sel;
        sel = NUM_COLS'(1) << col;
        return ~sel;
    endfunction

endpackage

FILE: sv/kmds_ctrl.sv
// Controller state machine of the keypad scanner.
// Depends on kmds_pkg; drives commands to kmds_datapath.
module kmds_ctrl
    import kmds_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_mode,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  kmds_status_t status,
    output kmds_cmd_t    cmd
);

    kmds_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_mode == MODE_POLL) ? ST_POLL : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan   = 1'b1;
                state_next = ST_DONE;
            end
            ST_POLL: begin
                cmd.poll_step = 1'b1;
                if (status.poll_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    a_onehot_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

    a_load_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_SCAN || state_reg == ST_POLL))
        else $error("accepted beat did not start work");

    a_scan_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |=> state_reg == ST_DONE)
        else $error("scan tick took more than one cycle");

    a_out_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("result loaded but not presented");

endmodule

FILE: sv/kmds_datapath.sv
// Datapath of the keypad scanner: per-key debounce histories, stable and
// reported levels, column pointer, poll sweep and output register.
// Depends on kmds_pkg; commanded by kmds_ctrl.
module kmds_datapath
    import kmds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [NUM_ROWS-1:0] s_row_levels,
    input  kmds_cmd_t           cmd,
    output kmds_status_t        status,
    output logic [NUM_COLS-1:0] m_column_drive,
    output logic                m_key_valid,
    output logic [KEY_W-1:0]    m_key_code
);

    localparam int KEYS = NUM_ROWS * NUM_COLS;

    logic [HISTORY_BITS-1:0] hist_reg [NUM_COLS][NUM_ROWS];
    logic [KEYS-1:0]         stable_reg;
    logic [KEYS-1:0]         reported_reg;
    logic [COL_W-1:0]        col_reg;
    logic [COL_W-1:0]        poll_col_reg;
    logic [NUM_ROWS-1:0]     rows_reg;
    logic                    found_reg;
    logic [KEY_W-1:0]        code_reg;
    logic [NUM_COLS-1:0]     drive_out_reg;
    logic                    valid_out_reg;
    logic [KEY_W-1:0]        code_out_reg;

    logic [HISTORY_BITS-1:0] hist_next [NUM_ROWS];
    logic [NUM_ROWS-1:0]     stable_col;
    logic [NUM_ROWS-1:0]     reported_col;
    logic [NUM_ROWS-1:0]     new_press;
    logic                    hit;
    logic [ROW_W-1:0]        hit_row;
    logic [KEY_W-1:0]        poll_base;

    assign poll_base = {poll_col_reg, ROW_W'(0)};

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            hist_next[r] = {hist_reg[col_reg][r][HISTORY_BITS-2:0], rows_reg[r]};
        end
    end

    // One column of the poll sweep; the highest newly pressed row wins.
    always_comb begin
        stable_col   = stable_reg[poll_base +: NUM_ROWS];
        reported_col = reported_reg[poll_base +: NUM_ROWS];
        new_press    = reported_col & ~stable_col;
        hit          = 1'b0;
        hit_row      = '0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (new_press[r]) begin
                hit     = 1'b1;
                hit_row = ROW_W'(r);
            end
        end
    end

    assign status.poll_last = (poll_col_reg == COL_W'(NUM_COLS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                for (int r = 0; r < NUM_ROWS; r++) begin
                    hist_reg[c][r] <= '1;
                end
            end
            stable_reg   <= '1;
            reported_reg <= '1;
            col_reg      <= '0;
            poll_col_reg <= '0;
        end else begin
            if (cmd.load) begin
                poll_col_reg <= '0;
            end
            if (cmd.scan) begin
                for (int r = 0; r < NUM_ROWS; r++) begin
                    hist_reg[col_reg][r] <= hist_next[r];
                    if (&hist_next[r]) begin
                        stable_reg[{col_reg, ROW_W'(r)}] <= 1'b1;
                    end else if (~|hist_next[r]) begin
                        stable_reg[{col_reg, ROW_W'(r)}] <= 1'b0;
                    end
                end
                col_reg <= col_reg + COL_W'(1);
            end
            if (cmd.poll_step) begin
                reported_reg[poll_base +: NUM_ROWS] <= stable_col;
                poll_col_reg <= poll_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rows_reg  <= s_row_levels;
            found_reg <= 1'b0;
            code_reg  <= '0;
        end else if (cmd.poll_step && hit) begin
            found_reg <= 1'b1;
            code_reg  <= KEY_W'({poll_col_reg, hit_row});
        end
        if (cmd.out_load) begin
            drive_out_reg <= drive_for(col_reg);
            valid_out_reg <= found_reg;
            code_out_reg  <= code_reg;
        end
    end

    assign m_column_drive = drive_out_reg;
    assign m_key_valid    = valid_out_reg;
    assign m_key_code     = code_out_reg;

endmodule

FILE: sv/keypad_matrix_debounce_scanner_unit.sv
// Top level of the 4x4 keypad scanner with shift-register debounce.
// Depends on kmds_pkg, kmds_ctrl and kmds_datapath.
//
// The block takes one beat at a time on the s_ channel and returns exactly
// one result beat on the m_ channel for each. A scan tick (s_mode low)
// shifts the four row levels, sampled while the current column was driven
// low, into that column's 8-bit key histories: a history of all ones makes
// the key stable released, all zeros stable pressed, anything else leaves
// it alone; the column pointer then advances and the result carries the
// active-low drive for the next column, with key_valid and key_code zero.
// A poll (s_mode high) copies every key's stable level into its reported
// level and reports the highest code (row + 4*column) of a key that went
// from released to pressed; releases are absorbed silently and the column
// drive shows the current column. A scan tick passes through accept,
// history update and result load before the next beat can be accepted;
// a poll passes through accept, the sweep, which compares one column of
// four keys per cycle over the four columns, and result load. The result
// sits in an output register, so a new beat can be accepted while the
// previous result still waits for m_ready; the block only stalls when a
// finished result finds that register still occupied.
module keypad_matrix_debounce_scanner_unit
    import kmds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [NUM_ROWS-1:0] s_row_levels,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [NUM_COLS-1:0] m_column_drive,
    output logic                m_key_valid,
    output logic [KEY_W-1:0]    m_key_code
);

    // Command and status groups between the controller and the datapath.
    kmds_cmd_t    cmd;
    kmds_status_t status;

    // The controller sequences each beat: capture, scan or poll sweep, then
    // hand-off to the output register.
    kmds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds all key state and the result payload.
    kmds_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_row_levels   (s_row_levels),
        .cmd            (cmd),
        .status         (status),
        .m_column_drive (m_column_drive),
        .m_key_valid    (m_key_valid),
        .m_key_code     (m_key_code)
    );

endmodule
